// File: rtl/core/opvd_pkg.sv
// ----------------------------------------------------------------------------
// opvd_pkg
// Shared types, formula codes and scaling constants for the PID value decoder.
// ----------------------------------------------------------------------------
package opvd_pkg;

  // Fixed point format of the result.
  localparam int FRACTION_BITS = 16;
  localparam int VALUE_WIDTH   = 37;

  // Reciprocal precision. 2^-RECIP_SHIFT * 2^16 stays below 1/1000, so the
  // rounded quotient is exact for every divisor in the formula set.
  localparam int RECIP_SHIFT  = 26;
  localparam int GAIN_SHIFT   = FRACTION_BITS + RECIP_SHIFT;

  // Datapath widths.
  localparam int SRC_WIDTH    = 16;                             // W = A*256+B
  localparam int GAIN_WIDTH   = GAIN_SHIFT + 4;                 // up to 10*2^GAIN_SHIFT
  localparam int OFFSET_WIDTH = FRACTION_BITS + 9;              // -210..20 scaled
  localparam int PROD_WIDTH   = SRC_WIDTH + GAIN_WIDTH;
  localparam int QUOT_WIDTH   = PROD_WIDTH - RECIP_SHIFT;       // W*10 < 2^20
  localparam int SUM_WIDTH    = QUOT_WIDTH + 2;                 // signed, with offset
  localparam int EXT_WIDTH    = (SUM_WIDTH > VALUE_WIDTH) ? SUM_WIDTH : VALUE_WIDTH;

  typedef logic [GAIN_WIDTH-1:0]          gain_t;
  typedef logic [RECIP_SHIFT-1:0]         bias_t;
  typedef logic signed [OFFSET_WIDTH-1:0] offset_t;

  // Formula codes, in table order.
  typedef enum logic [4:0] {
    FN_A,
    FN_B,
    FN_C,
    FN_A_M40,
    FN_A_M50,
    FN_A_M64,
    FN_A_M125,
    FN_A_P20,
    FN_A_X3,
    FN_A_PCT,
    FN_A_HALF_M64,
    FN_A_128_M100,
    FN_W_D4,
    FN_W_D10_M40,
    FN_W_D20,
    FN_W_D100,
    FN_W_D128_M210,
    FN_W_D1000,
    FN_W_D200,
    FN_W_PCT,
    FN_W_D32768,
    FN_W_X10,
    FN_W,
    FN_A_RATIO,
    FN_B_RATIO,
    FN_C_RATIO,
    FN_B_NOT_2
  } formula_e;

  // Source operand of the scaling multiply.
  typedef enum logic [2:0] {
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_W,
    SRC_FLAG
  } src_e;

  // Gains: ceil(mul * 2^GAIN_SHIFT / div).
  localparam gain_t GAIN_ONE  = gain_t'(64'd1 << GAIN_SHIFT);
  localparam gain_t GAIN_X3   = gain_t'(64'd3 << GAIN_SHIFT);
  localparam gain_t GAIN_X10  = gain_t'(64'd10 << GAIN_SHIFT);
  localparam gain_t GAIN_PCT  = gain_t'(((64'd100 << GAIN_SHIFT) + 64'd254) / 64'd255);
  localparam gain_t GAIN_P128 = gain_t'(((64'd100 << GAIN_SHIFT) + 64'd127) / 64'd128);
  localparam gain_t GAIN_D2   = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd1) / 64'd2);
  localparam gain_t GAIN_D4   = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd3) / 64'd4);
  localparam gain_t GAIN_D10  = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd9) / 64'd10);
  localparam gain_t GAIN_D20  = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd19) / 64'd20);
  localparam gain_t GAIN_D100 = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd99) / 64'd100);
  localparam gain_t GAIN_D128 = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd127) / 64'd128);
  localparam gain_t GAIN_D200 = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd199) / 64'd200);
  localparam gain_t GAIN_D1K  = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd999) / 64'd1000);
  localparam gain_t GAIN_D32K = gain_t'(((64'd1 << GAIN_SHIFT) + 64'd32767) / 64'd32768);

  // Rounding biases: ceil((div/2) * 2^RECIP_SHIFT / div).
  localparam bias_t BIAS_NONE = '0;
  localparam bias_t BIAS_D2   = bias_t'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2);
  localparam bias_t BIAS_D4   = bias_t'(((64'd2 << RECIP_SHIFT) + 64'd3) / 64'd4);
  localparam bias_t BIAS_D10  = bias_t'(((64'd5 << RECIP_SHIFT) + 64'd9) / 64'd10);
  localparam bias_t BIAS_D20  = bias_t'(((64'd10 << RECIP_SHIFT) + 64'd19) / 64'd20);
  localparam bias_t BIAS_D100 = bias_t'(((64'd50 << RECIP_SHIFT) + 64'd99) / 64'd100);
  localparam bias_t BIAS_D128 = bias_t'(((64'd64 << RECIP_SHIFT) + 64'd127) / 64'd128);
  localparam bias_t BIAS_D200 = bias_t'(((64'd100 << RECIP_SHIFT) + 64'd199) / 64'd200);
  localparam bias_t BIAS_D255 = bias_t'(((64'd127 << RECIP_SHIFT) + 64'd254) / 64'd255);
  localparam bias_t BIAS_D1K  = bias_t'(((64'd500 << RECIP_SHIFT) + 64'd999) / 64'd1000);
  localparam bias_t BIAS_D32K = bias_t'(((64'd16384 << RECIP_SHIFT) + 64'd32767) / 64'd32768);

  // Offsets, already scaled by 2^FRACTION_BITS.
  localparam offset_t OFF_NONE = '0;
  localparam offset_t OFF_M40  = offset_t'(-64'sd40 <<< FRACTION_BITS);
  localparam offset_t OFF_M50  = offset_t'(-64'sd50 <<< FRACTION_BITS);
  localparam offset_t OFF_M64  = offset_t'(-64'sd64 <<< FRACTION_BITS);
  localparam offset_t OFF_M100 = offset_t'(-64'sd100 <<< FRACTION_BITS);
  localparam offset_t OFF_M125 = offset_t'(-64'sd125 <<< FRACTION_BITS);
  localparam offset_t OFF_M210 = offset_t'(-64'sd210 <<< FRACTION_BITS);
  localparam offset_t OFF_P20  = offset_t'(64'sd20 <<< FRACTION_BITS);

  // Per-formula scaling controls.
  typedef struct packed {
    src_e    src;
    gain_t   gain;
    bias_t   bias;
    offset_t offset;
    logic    unknown;
  } coef_t;

  typedef struct packed {
    logic [4:0] func;
    logic [5:0] slot;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [5:0]                    slot_out;
    logic                          unknown_formula;
  } out_item_t;

endpackage

// File: rtl/core/opvd_formula_decode.sv
// ----------------------------------------------------------------------------
// opvd_formula_decode
// Maps a formula code to its source select, gain, rounding bias and offset.
// ----------------------------------------------------------------------------
module opvd_formula_decode (
  input  logic [4:0]      func_i,
  output opvd_pkg::coef_t coef_o
);

  function automatic opvd_pkg::coef_t mk(opvd_pkg::src_e s, opvd_pkg::gain_t g,
                                         opvd_pkg::bias_t b, opvd_pkg::offset_t o);
    opvd_pkg::coef_t c;
    c = '{src: s, gain: g, bias: b, offset: o, unknown: 1'b0};
    return c;
  endfunction

  always_comb begin
    unique case (func_i) inside
      opvd_pkg::FN_A: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_B: begin
        coef_o = mk(opvd_pkg::SRC_B, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_C: begin
        coef_o = mk(opvd_pkg::SRC_C, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_A_M40: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_M40);
      end
      opvd_pkg::FN_A_M50: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_M50);
      end
      opvd_pkg::FN_A_M64: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_M64);
      end
      opvd_pkg::FN_A_M125: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_M125);
      end
      opvd_pkg::FN_A_P20: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_P20);
      end
      opvd_pkg::FN_A_X3: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_X3, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_A_PCT, opvd_pkg::FN_A_RATIO: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_PCT, opvd_pkg::BIAS_D255, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_A_HALF_M64: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_D2, opvd_pkg::BIAS_D2, opvd_pkg::OFF_M64);
      end
      opvd_pkg::FN_A_128_M100: begin
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_P128, opvd_pkg::BIAS_D128,
                    opvd_pkg::OFF_M100);
      end
      opvd_pkg::FN_W_D4: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D4, opvd_pkg::BIAS_D4, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_D10_M40: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D10, opvd_pkg::BIAS_D10, opvd_pkg::OFF_M40);
      end
      opvd_pkg::FN_W_D20: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D20, opvd_pkg::BIAS_D20, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_D100: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D100, opvd_pkg::BIAS_D100,
                    opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_D128_M210: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D128, opvd_pkg::BIAS_D128,
                    opvd_pkg::OFF_M210);
      end
      opvd_pkg::FN_W_D1000: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D1K, opvd_pkg::BIAS_D1K, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_D200: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D200, opvd_pkg::BIAS_D200,
                    opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_PCT: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_PCT, opvd_pkg::BIAS_D255, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_D32768: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_D32K, opvd_pkg::BIAS_D32K,
                    opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W_X10: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_X10, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_W: begin
        coef_o = mk(opvd_pkg::SRC_W, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_B_RATIO: begin
        coef_o = mk(opvd_pkg::SRC_B, opvd_pkg::GAIN_PCT, opvd_pkg::BIAS_D255, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_C_RATIO: begin
        coef_o = mk(opvd_pkg::SRC_C, opvd_pkg::GAIN_PCT, opvd_pkg::BIAS_D255, opvd_pkg::OFF_NONE);
      end
      opvd_pkg::FN_B_NOT_2: begin
        // flag bit goes through the unity path
        coef_o = mk(opvd_pkg::SRC_FLAG, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE,
                    opvd_pkg::OFF_NONE);
      end
      default: begin
        // unrecognized code: plain A, flagged
        coef_o = mk(opvd_pkg::SRC_A, opvd_pkg::GAIN_ONE, opvd_pkg::BIAS_NONE, opvd_pkg::OFF_NONE);
        coef_o.unknown = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/opvd_scale.sv
// ----------------------------------------------------------------------------
// opvd_scale
// Source select, reciprocal multiply with rounding, offset add and saturation.
// ----------------------------------------------------------------------------
module opvd_scale (
  input  opvd_pkg::coef_t                        coef_i,
  input  logic [7:0]                             byte_a_i,
  input  logic [7:0]                             byte_b_i,
  input  logic [7:0]                             byte_c_i,
  output logic signed [opvd_pkg::VALUE_WIDTH-1:0] value_o
);

  localparam int PW = opvd_pkg::PROD_WIDTH;
  localparam int SW = opvd_pkg::SUM_WIDTH;
  localparam int EW = opvd_pkg::EXT_WIDTH;

  localparam logic signed [EW-1:0] VMAX =
    EW'((64'sd1 <<< (opvd_pkg::VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

  logic [opvd_pkg::SRC_WIDTH-1:0]  src;
  logic [PW-1:0]                   prod;
  logic [PW-1:0]                   acc;
  logic [opvd_pkg::QUOT_WIDTH-1:0] quot;
  logic signed [SW-1:0]            scaled;
  logic signed [EW-1:0]            ext;
  logic signed [EW-1:0]            sat;

  always_comb begin
    unique case (coef_i.src)
      opvd_pkg::SRC_A:    src = {8'b0, byte_a_i};
      opvd_pkg::SRC_B:    src = {8'b0, byte_b_i};
      opvd_pkg::SRC_C:    src = {8'b0, byte_c_i};
      opvd_pkg::SRC_W:    src = {byte_a_i, byte_b_i};
      opvd_pkg::SRC_FLAG: src = {15'b0, (byte_b_i != 8'd2)};
      default:            src = '0;
    endcase
  end

  // q = floor((x*gain + bias) / 2^RECIP_SHIFT)
  assign prod   = PW'(src) * PW'(coef_i.gain);
  assign acc    = prod + PW'(coef_i.bias);
  assign quot   = acc[PW-1:opvd_pkg::RECIP_SHIFT];
  assign scaled = $signed({2'b00, quot}) + SW'(coef_i.offset);
  assign ext    = EW'(scaled);

  always_comb begin
    if (ext > VMAX) begin
      sat = VMAX;
    end else if (ext < VMIN) begin
      sat = VMIN;
    end else begin
      sat = ext;
    end
  end

  assign value_o = sat[opvd_pkg::VALUE_WIDTH-1:0];

endmodule

// File: rtl/core/obd_pid_value_decoder_core.sv
// ----------------------------------------------------------------------------
// obd_pid_value_decoder_core
// Scales decoded OBD-II PID data bytes to signed fixed point sensor values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item per reply,
//   carrying the formula code, the slot index and data bytes A, B, C (absent
//   bytes as zero). An item is taken at a clock edge where valid is high and
//   stall is low.
//   Output channel (out_valid_o / out_stall_i / out_item_o): one result item
//   per input item, in order: value with FRACTION_BITS fraction bits, the
//   slot copied through and an unknown-formula flag.
//   Path: the input register takes the item at the accepting edge, then the
//   result register takes its result once it is empty or draining; out_valid_o
//   rises when the result register loads.
//   Throughput: one item per cycle while out_stall_i stays low, set by the
//   single multiply-add-saturate pass between the two registers.
//   Stall: the result register holds while out_stall_i is high; the input
//   register takes one more item only if it is empty, then in_stall_o rises.
//   Reset: rst_ni low clears both valid flags; no item is in flight after.
// ----------------------------------------------------------------------------
module obd_pid_value_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  opvd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output opvd_pkg::out_item_t out_item_o
);

  // Stage registers.
  logic                in_valid_q, in_valid_d;
  opvd_pkg::in_item_t  in_item_q;
  logic                out_valid_q, out_valid_d;
  opvd_pkg::out_item_t out_item_q, out_item_d;

  // Handshake: each stage may load when empty or when it is draining.
  logic out_ready;
  logic in_ready;

  opvd_pkg::coef_t                        coef;
  logic signed [opvd_pkg::VALUE_WIDTH-1:0] value;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_ready  = !in_valid_q || out_ready;

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Formula lookup and arithmetic, all on the registered input item.
  opvd_formula_decode u_decode (
    .func_i (in_item_q.func),
    .coef_o (coef)
  );

  opvd_scale u_scale (
    .coef_i   (coef),
    .byte_a_i (in_item_q.byte_a),
    .byte_b_i (in_item_q.byte_b),
    .byte_c_i (in_item_q.byte_c),
    .value_o  (value)
  );

  always_comb begin
    in_valid_d  = in_ready ? in_valid_i : in_valid_q;
    out_valid_d = out_ready ? in_valid_q : out_valid_q;

    out_item_d.value           = value;
    out_item_d.slot_out        = in_item_q.slot;
    out_item_d.unknown_formula = coef.unknown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset needed, loads only with a valid item.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (out_ready && in_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

// File: rtl/core/opvd_checker.sv
// ----------------------------------------------------------------------------
// opvd_checker
// Port-level checks on flow and result content, bound to the top level.
// ----------------------------------------------------------------------------
module opvd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input opvd_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input opvd_pkg::out_item_t out_item_o
);

  localparam int VW = opvd_pkg::VALUE_WIDTH;
  localparam int FB = opvd_pkg::FRACTION_BITS;
  localparam logic [VW-1:0] ONE_VAL = VW'(64'd1 << FB);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // empty output stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // result follows unless stalled, slot carried through
  a_latency_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i |=>
      out_valid_o && (out_item_o.slot_out == $past(in_item_i.slot, 2)))
    else $error("result late or slot mismatch");

  // B-not-2 flag formula
  a_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.func == opvd_pkg::FN_B_NOT_2)) ##1 !out_stall_i |=>
      !out_item_o.unknown_formula &&
      (out_item_o.value == (($past(in_item_i.byte_b, 2) != 8'd2) ? ONE_VAL : '0)))
    else $error("flag formula value wrong");

  // unknown code gives A, flagged
  a_unknown_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.func > opvd_pkg::FN_B_NOT_2)) ##1 !out_stall_i |=>
      out_item_o.unknown_formula &&
      (out_item_o.value == {{(VW - 8 - FB){1'b0}}, $past(in_item_i.byte_a, 2), {FB{1'b0}}}))
    else $error("unknown formula result wrong");

endmodule

bind obd_pid_value_decoder_core opvd_checker u_opvd_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for obd_pid_value_decoder_core: directed formula and
// byte extremes, then random replies under four sender/receiver idle mixes,
// each result checked in order against a fixed point scaling predictor.
// ----------------------------------------------------------------------------
module testbench;
  import opvd_pkg::*;

  localparam int unsigned RAND_ITEMS   = 1500;
  localparam int unsigned PHASE_COUNT  = 4;
  localparam int unsigned SETTLE_TICKS = 8;        // result path is two registers deep
  localparam int unsigned CYCLE_LIMIT  = 400000;   // far above the slowest legal run

  // Tracks predicted sensor readings and compares them with decoder output.
  class pid_reading_board;
    out_item_t   awaited_readings[$];
    int unsigned mismatches = 0;

    // Exact rational evaluation: x*mul/div + off, scaled by 2^FRACTION_BITS,
    // quotient rounded to nearest with halves up, then clamped to the field.
    function out_item_t scale_reading(in_item_t req);
      longint    x, mul, div, off, one, v, maxv;
      out_item_t res;
      one = longint'(1) << FRACTION_BITS;
      x   = req.byte_a;
      mul = 1;
      div = 1;
      off = 0;
      res.unknown_formula = 1'b0;
      case (req.func)
        FN_A:           ;
        FN_B:           x = req.byte_b;
        FN_C:           x = req.byte_c;
        FN_A_M40:       off = -40;
        FN_A_M50:       off = -50;
        FN_A_M64:       off = -64;
        FN_A_M125:      off = -125;
        FN_A_P20:       off = 20;
        FN_A_X3:        mul = 3;
        FN_A_PCT:       begin mul = 100; div = 255; end
        FN_A_HALF_M64:  begin div = 2; off = -64; end
        FN_A_128_M100:  begin mul = 100; div = 128; off = -100; end
        FN_W_D4:        begin x = {req.byte_a, req.byte_b}; div = 4; end
        FN_W_D10_M40:   begin x = {req.byte_a, req.byte_b}; div = 10; off = -40; end
        FN_W_D20:       begin x = {req.byte_a, req.byte_b}; div = 20; end
        FN_W_D100:      begin x = {req.byte_a, req.byte_b}; div = 100; end
        FN_W_D128_M210: begin x = {req.byte_a, req.byte_b}; div = 128; off = -210; end
        FN_W_D1000:     begin x = {req.byte_a, req.byte_b}; div = 1000; end
        FN_W_D200:      begin x = {req.byte_a, req.byte_b}; div = 200; end
        FN_W_PCT:       begin x = {req.byte_a, req.byte_b}; mul = 100; div = 255; end
        FN_W_D32768:    begin x = {req.byte_a, req.byte_b}; div = 32768; end
        FN_W_X10:       begin x = {req.byte_a, req.byte_b}; mul = 10; end
        FN_W:           x = {req.byte_a, req.byte_b};
        FN_A_RATIO:     begin mul = 100; div = 255; end
        FN_B_RATIO:     begin x = req.byte_b; mul = 100; div = 255; end
        FN_C_RATIO:     begin x = req.byte_c; mul = 100; div = 255; end
        FN_B_NOT_2:     x = (req.byte_b != 8'd2) ? 1 : 0;
        default:        res.unknown_formula = 1'b1;   // unrecognized code: plain A
      endcase
      v    = (x * mul * one + div / 2) / div + off * one;
      maxv = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
      if (v > maxv) v = maxv;
      if (v < -maxv - 1) v = -maxv - 1;
      res.value    = v[VALUE_WIDTH-1:0];
      res.slot_out = req.slot;
      return res;
    endfunction

    function void note_request(in_item_t req);
      awaited_readings.push_back(scale_reading(req));
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (awaited_readings.size() == 0) begin
        $error("unexpected result item: slot_out %0d value %0d", got.slot_out, got.value);
        mismatches++;
        return;
      end
      want = awaited_readings.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d actual %0d", want.value, got.value);
        mismatches++;
      end
      if (got.slot_out !== want.slot_out) begin
        $error("slot_out: expected %0d actual %0d", want.slot_out, got.slot_out);
        mismatches++;
      end
      if (got.unknown_formula !== want.unknown_formula) begin
        $error("unknown_formula: expected %0b actual %0b",
               want.unknown_formula, got.unknown_formula);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_readings.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  pid_reading_board readings = new();

  // Idle mix, percent of cycles; changed only between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  obd_pid_value_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stall, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor: values sampled here are the ones present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readings.check_reading(out_item_o);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Skewed byte: extremes turn up often, the rest is uniform.
  function automatic logic [7:0] edge_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    req.func   = 5'($urandom_range(31));
    req.slot   = 6'($urandom_range(63));
    req.byte_a = edge_byte();
    req.byte_b = ($urandom_range(9) == 0) ? 8'd2 : edge_byte();  // hit the B==2 flag case
    req.byte_c = edge_byte();
    return req;
  endfunction

  // Presents one item and holds it until taken. Valid stays high on exit so
  // back-to-back items need no drop in between.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    readings.note_request(req);
  endtask

  // Sender holds off until every predicted reading has come back.
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (readings.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t req;
    int unsigned per_phase;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every formula with all bytes at one extreme, alternating
    // between full scale and zero, slot at its ends.
    for (int code = 0; code <= int'(FN_B_NOT_2); code++) begin
      req.func   = 5'(code);
      req.slot   = (code % 2 == 0) ? 6'h3F : 6'h00;
      req.byte_a = (code % 2 == 0) ? 8'hFF : 8'h00;
      req.byte_b = req.byte_a;
      req.byte_c = req.byte_a;
      send_request(req);
    end
    // Flag formula with B exactly 2, and unknown codes at both ends.
    req = '{func: FN_B_NOT_2, slot: 6'd21, byte_a: 8'h00, byte_b: 8'd2, byte_c: 8'h00};
    send_request(req);
    req = '{func: 5'd27, slot: 6'd42, byte_a: 8'hFF, byte_b: 8'hFF, byte_c: 8'hFF};
    send_request(req);
    req = '{func: 5'd31, slot: 6'd63, byte_a: 8'h80, byte_b: 8'h01, byte_c: 8'h7F};
    send_request(req);
    drain_readings();

    // Random, one idle mix per phase; full drain between phases.
    per_phase = RAND_ITEMS / PHASE_COUNT;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        send_request(random_request());
      end
      drain_readings();
    end

    recv_stall_pct = 0;
    drain_readings();
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (readings.mismatches == 0 && readings.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: obd_pid_value_decoder_core.f
rtl/core/opvd_pkg.sv
rtl/core/opvd_formula_decode.sv
rtl/core/opvd_scale.sv
rtl/core/obd_pid_value_decoder_core.sv
rtl/core/opvd_checker.sv
tb/sv/testbench.sv
